// ----- sv/a2i_pkg.sv -----
// ----------------------------------------------------------------------------
// a2i_pkg: shared constants and helpers for the ASCII-to-integer parser
// Phase codes, radix limits, widths, character codes, the blank test and the digit decoder.
// ----------------------------------------------------------------------------
package a2i_pkg;

  // Parser phase codes
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_LEAD   = 3'd1;
  localparam logic [2:0] PH_SIGNED = 3'd2;
  localparam logic [2:0] PH_ZERO   = 3'd3;
  localparam logic [2:0] PH_DIGITS = 3'd4;

  // Radix limits and reset value
  localparam int unsigned RADIX_W     = 6;
  localparam logic [5:0]  RADIX_MIN   = 6'd2;
  localparam logic [5:0]  RADIX_MAX   = 6'd36;
  localparam logic [5:0]  RADIX_HEX   = 6'd16;
  localparam logic [5:0]  RADIX_RESET = 6'd10;

  // Accumulator and result widths
  localparam int unsigned ACC_W   = 64;
  localparam int unsigned VALUE_W = 32;

  // Character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;

  // Digit value of a character; 64 marks a non-digit
  localparam logic [6:0] NO_DIGIT = 7'd64;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic [6:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'(NO_DIGIT);
    if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
      d = c - CH_ZERO;
    end else if ((c >= CH_LO_A) && (c <= CH_LO_Z)) begin
      d = c - CH_LO_A + 8'd10;
    end else if ((c >= CH_UP_A) && (c <= CH_UP_Z)) begin
      d = c - CH_UP_A + 8'd10;
    end
    return d[6:0];
  endfunction

endpackage

// ----- sv/ascii_to_integer_any_base.sv -----
// ----------------------------------------------------------------------------
// ascii_to_integer_any_base: character-serial integer parser, radix 2 to 36
// Skips blanks, takes a sign and, in radix 16, a 0x prefix, accumulates digits in 64 bits
// and reports one 32-bit value at the first non-digit of each string (minus one if the radix is out of range).
// ----------------------------------------------------------------------------
// An input transfer is captured in the input register; the parse logic then
//   writes the result register, which drives out_value.
// Throughput: one character per cycle while not stalled; the parse state updates on each accepted character.
//   A character that ends a string stalls only while an earlier result waits.
// Reset (rst_n low, synchronous): pipeline empty, parser idle, radix = 10.
// ----------------------------------------------------------------------------
module ascii_to_integer_any_base (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_ch,
  input  logic        in_first,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_value,
  // radix register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data
);

  // Radix register
  logic [a2i_pkg::RADIX_W-1:0] radix_r;

  // Input register
  logic       s1_valid_r;
  logic [7:0] s1_ch_r;
  logic       s1_first_r;

  // Parser state
  logic [2:0]                phase_r, phase_nxt;
  logic                      neg_r, neg_nxt;
  logic [a2i_pkg::ACC_W-1:0] acc_r, acc_nxt;

  // Result register
  logic                        out_valid_r;
  logic [a2i_pkg::VALUE_W-1:0] out_value_r;

  // Parse results
  logic                        has_res;
  logic [a2i_pkg::VALUE_W-1:0] res_value;
  logic                        s1_adv, s1_fire, in_fire;
  logic                        radix_bad;
  logic [a2i_pkg::ACC_W+a2i_pkg::RADIX_W-1:0] prod;
  logic [6:0]                  dig;

  assign cfg_ready = 1'b1;
  assign radix_bad = (radix_r < a2i_pkg::RADIX_MIN) || (radix_r > a2i_pkg::RADIX_MAX);
  assign dig       = a2i_pkg::digit_of(s1_ch_r);
  // a string start clears the accumulator before its first digit
  assign prod      = s1_first_r ? '0 : acc_r * radix_r;

  // Parse one character against the current state
  always_comb begin
    logic [2:0]                p;
    logic                      done;
    logic                      neg_v;
    logic [a2i_pkg::ACC_W-1:0] acc_v;
    logic [a2i_pkg::VALUE_W-1:0] lo;
    p         = s1_first_r ? a2i_pkg::PH_LEAD : phase_r;
    neg_v     = s1_first_r ? 1'b0 : neg_r;
    acc_v     = s1_first_r ? '0 : acc_r;
    done      = 1'b0;
    has_res   = 1'b0;
    res_value = '1;
    phase_nxt = p;
    neg_nxt   = neg_v;
    acc_nxt   = acc_v;
    lo        = acc_v[a2i_pkg::VALUE_W-1:0];
    if (p == a2i_pkg::PH_IDLE) begin
      done = 1'b1;
    end else if (radix_bad) begin
      done      = 1'b1;
      has_res   = 1'b1;
      phase_nxt = a2i_pkg::PH_IDLE;
    end
    // leading blanks and sign
    if (!done && (p == a2i_pkg::PH_LEAD)) begin
      if (a2i_pkg::is_blank(s1_ch_r)) begin
        done = 1'b1;
      end else if ((s1_ch_r == a2i_pkg::CH_PLUS) || (s1_ch_r == a2i_pkg::CH_MINUS)) begin
        neg_nxt   = (s1_ch_r == a2i_pkg::CH_MINUS);
        phase_nxt = a2i_pkg::PH_SIGNED;
        done      = 1'b1;
      end else begin
        p = a2i_pkg::PH_SIGNED;
      end
    end
    // hex prefix
    if (!done) begin
      if (p == a2i_pkg::PH_SIGNED) begin
        if ((radix_r == a2i_pkg::RADIX_HEX) && (s1_ch_r == a2i_pkg::CH_ZERO)) begin
          phase_nxt = a2i_pkg::PH_ZERO;
          done      = 1'b1;
        end else begin
          p = a2i_pkg::PH_DIGITS;
        end
      end else if (p == a2i_pkg::PH_ZERO) begin
        p = a2i_pkg::PH_DIGITS;
        if ((s1_ch_r == a2i_pkg::CH_LO_X) || (s1_ch_r == a2i_pkg::CH_UP_X)) begin
          phase_nxt = a2i_pkg::PH_DIGITS;
          done      = 1'b1;
        end
      end
    end
    // digit accumulate or end of string
    if (!done) begin
      if (dig < {1'b0, radix_r}) begin
        phase_nxt = a2i_pkg::PH_DIGITS;
        acc_nxt   = prod[a2i_pkg::ACC_W-1:0] + a2i_pkg::ACC_W'(dig);
      end else begin
        phase_nxt = a2i_pkg::PH_IDLE;
        has_res   = 1'b1;
        if (neg_v) begin
          res_value = '0 - lo;
        end else if (acc_v[a2i_pkg::ACC_W-1]) begin
          res_value = '1;
        end else begin
          res_value = lo;
        end
      end
    end
  end

  // Handshake: hold a result-producing character while the result register is blocked
  assign s1_adv   = !(has_res && out_valid_r && out_stall);
  assign s1_fire  = s1_valid_r && s1_adv;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_fire  = in_valid && !in_stall;

  // Radix register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= a2i_pkg::RADIX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      radix_r <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ch_r    <= in_ch;
      s1_first_r <= in_first;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= a2i_pkg::PH_IDLE;
      neg_r   <= 1'b0;
      acc_r   <= '0;
    end else if (s1_fire) begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      acc_r   <= acc_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && has_res) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && has_res) begin
      out_value_r <= res_value;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  // Checks
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty input register");

  a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_adv && has_res) |=> out_valid_r)
    else $error("ending character produced no result");

  a_bad_radix_idles: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && radix_bad && (s1_first_r || (phase_r != a2i_pkg::PH_IDLE)))
      |=> (phase_r == a2i_pkg::PH_IDLE) && (out_value_r == '1))
    else $error("invalid radix did not end the string with minus one");

endmodule
